// ----- rtl/core/poe_pkg.sv -----
`timescale 1ns / 1ps

package poe_pkg;

    localparam int XY_W      = 32;
    localparam int DIFF_W    = 33;
    localparam int MUL_A_W   = 68;
    localparam int MUL_B_W   = 34;
    localparam int DIG_W     = 17;
    localparam int PROD_W    = 102;
    localparam int DEN_W     = 68;
    localparam int PERP_W    = 49;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_DISTANCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_TOLERANCE = 2'd1;

    localparam logic [31:0] OFFSET_DISTANCE_RESET    = 32'd65536;
    localparam logic [31:0] PARALLEL_TOLERANCE_RESET = 32'd1;

    typedef struct packed {
        logic signed [XY_W-1:0] vertex_x;
        logic signed [XY_W-1:0] vertex_y;
        logic                   vertex_last;
    } vertex_t;

    typedef struct packed {
        logic signed [XY_W-1:0] out_x;
        logic signed [XY_W-1:0] out_y;
        logic                   parallel_error;
        logic                   out_last;
    } result_t;

    typedef enum logic [1:0] {
        PH_EMPTY   = 2'd0,
        PH_VERTEX  = 2'd1,
        PH_SEGMENT = 2'd2
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P0,
        ST_PX,
        ST_PY,
        ST_SEG,
        ST_C1A,
        ST_C1B,
        ST_C2A,
        ST_C2B,
        ST_DETA,
        ST_DETB,
        ST_NXA,
        ST_NXB,
        ST_NYA,
        ST_NYB,
        ST_CHECK,
        ST_DIVX,
        ST_DIVY,
        ST_EMIT_A,
        ST_EMIT_B
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PX,
        OP_PY,
        OP_SEG,
        OP_C1A,
        OP_C1B,
        OP_C2A,
        OP_C2B,
        OP_DETA,
        OP_DETB,
        OP_NXA,
        OP_NXB,
        OP_NYA,
        OP_NYB,
        OP_CHECK,
        OP_DIVX,
        OP_DIVY
    } dp_op_t;

    typedef enum logic [1:0] {
        EM_START,
        EM_INTER,
        EM_END,
        EM_ERR
    } emit_sel_t;

    typedef struct packed {
        dp_op_t    op;
        logic      mul_start;
        logic      div_start;
        logic      emit;
        emit_sel_t emit_sel;
        logic      commit;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic parallel;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/poe_mul.sv -----
`timescale 1ns / 1ps

module poe_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [poe_pkg::MUL_A_W-1:0]  a,
    input  logic signed [poe_pkg::MUL_B_W-1:0]  b,
    output logic                                done,
    output logic signed [poe_pkg::PROD_W-1:0]   prod
);
    import poe_pkg::*;

    localparam int PP_W = MUL_A_W + DIG_W;

    logic                  busy_reg, busy_next;
    logic                  fin_reg, fin_next;
    logic                  idx_reg, idx_next;
    logic                  done_reg, done_next;
    logic [MUL_A_W-1:0]    am_reg;
    logic [MUL_B_W-1:0]    bm_reg;
    logic                  neg_reg;
    logic [PROD_W-1:0]     acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DIG_W-1:0]      digit;
    logic [PP_W-1:0]       pp;

    // high digit first, shift-accumulate
    assign digit = idx_reg ? bm_reg[MUL_B_W-1:DIG_W] : bm_reg[DIG_W-1:0];
    assign pp    = PP_W'(am_reg) * PP_W'(digit);

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        idx_next  = idx_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            idx_next = 1'b0;
            if (!idx_reg)
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            idx_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            idx_reg  <= idx_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            am_reg  <= a[MUL_A_W-1] ? MUL_A_W'(-a) : MUL_A_W'(a);
            bm_reg  <= b[MUL_B_W-1] ? MUL_B_W'(-b) : MUL_B_W'(b);
            neg_reg <= a[MUL_A_W-1] ^ b[MUL_B_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[PROD_W-DIG_W-1:0], {DIG_W{1'b0}}} + PROD_W'(pp);
        end
        if (fin_reg)
        begin
            prod_reg <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ----- rtl/core/poe_div.sv -----
`timescale 1ns / 1ps

module poe_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [poe_pkg::PROD_W-1:0]  num,
    input  logic signed [poe_pkg::DEN_W-1:0]   den,
    output logic                               done,
    output logic signed [poe_pkg::PROD_W-1:0]  quot
);
    import poe_pkg::*;

    localparam int STEPS = PROD_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                  busy_reg, busy_next;
    logic                  fin_reg, fin_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PROD_W-1:0]     nq_reg;
    logic [DEN_W-1:0]      dm_reg;
    logic [DEN_W-1:0]      rem_reg;
    logic                  neg_reg;
    logic signed [PROD_W-1:0] quot_reg;
    logic [DEN_W:0]        trial;
    logic                  ge;

    // restoring, one quotient bit per cycle
    assign trial = {rem_reg, nq_reg[PROD_W-1]};
    assign ge    = trial >= {1'b0, dm_reg};

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nq_reg  <= num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
            dm_reg  <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            rem_reg <= '0;
            neg_reg <= num[PROD_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DEN_W'(trial - {1'b0, dm_reg}) : DEN_W'(trial);
            nq_reg  <= {nq_reg[PROD_W-2:0], ge};
        end
        if (fin_reg)
        begin
            quot_reg <= neg_reg ? -$signed(nq_reg) : $signed(nq_reg);
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/core/poe_datapath.sv -----
`timescale 1ns / 1ps

module poe_datapath #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  poe_pkg::dp_cmd_t                    cmd,
    output poe_pkg::dp_status_t                 status,
    input  poe_pkg::vertex_t                    vertex,
    input  logic                                cfg_we,
    input  logic [poe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                         cfg_data,
    output poe_pkg::result_t                    result,
    output logic                                result_valid,
    input  logic                                result_stall
);
    import poe_pkg::*;

    localparam int SAT_W = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam logic signed [PROD_W-1:0] SAT_MAX = (PROD_W'(1) <<< (SAT_W - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -(PROD_W'(1) <<< (SAT_W - 1));

    function automatic logic signed [XY_W-1:0] sat(input logic signed [PROD_W-1:0] v);
        logic signed [XY_W-1:0] r;
        if (v > SAT_MAX)
            r = XY_W'(SAT_MAX);
        else if (v < SAT_MIN)
            r = XY_W'(SAT_MIN);
        else
            r = XY_W'(v);
        return r;
    endfunction

    logic signed [31:0]        dist_reg;
    logic [31:0]               tol_reg;
    logic signed [XY_W-1:0]    vx_reg, vy_reg, pvx_reg, pvy_reg;
    logic signed [XY_W-1:0]    ssx_reg, ssy_reg, sex_reg, sey_reg;
    logic signed [XY_W-1:0]    nsx_reg, nsy_reg, nex_reg, ney_reg;
    logic signed [PERP_W-1:0]  px_reg, py_reg;
    logic signed [MUL_A_W-1:0] c1_reg, c2_reg;
    logic signed [DEN_W-1:0]   det_reg;
    logic signed [PROD_W-1:0]  nx_reg, ny_reg;
    logic signed [XY_W-1:0]    rx_reg, ry_reg;
    logic                      perr_reg;
    result_t                   out_reg;
    logic                      out_valid_reg, out_valid_next;

    logic signed [DIFF_W-1:0]  dvx, dvy, a1, b1, a2, b2;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod, quot, div_num;
    logic                      mul_done, div_done;
    logic [DEN_W-1:0]          det_abs;
    logic                      parallel;
    result_t                   emit_val;

    assign dvx = DIFF_W'(vx_reg) - DIFF_W'(pvx_reg);
    assign dvy = DIFF_W'(vy_reg) - DIFF_W'(pvy_reg);
    assign a1  = DIFF_W'(sey_reg) - DIFF_W'(ssy_reg);
    assign b1  = DIFF_W'(ssx_reg) - DIFF_W'(sex_reg);
    assign a2  = DIFF_W'(ney_reg) - DIFF_W'(nsy_reg);
    assign b2  = DIFF_W'(nsx_reg) - DIFF_W'(nex_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_PX:   begin mul_a = -MUL_A_W'(dvy); mul_b = MUL_B_W'(dist_reg); end
            OP_PY:   begin mul_a = MUL_A_W'(dvx);  mul_b = MUL_B_W'(dist_reg); end
            OP_C1A:  begin mul_a = MUL_A_W'(a1);   mul_b = MUL_B_W'(ssx_reg); end
            OP_C1B:  begin mul_a = MUL_A_W'(b1);   mul_b = MUL_B_W'(ssy_reg); end
            OP_C2A:  begin mul_a = MUL_A_W'(a2);   mul_b = MUL_B_W'(nsx_reg); end
            OP_C2B:  begin mul_a = MUL_A_W'(b2);   mul_b = MUL_B_W'(nsy_reg); end
            OP_DETA: begin mul_a = MUL_A_W'(a1);   mul_b = MUL_B_W'(b2); end
            OP_DETB: begin mul_a = MUL_A_W'(a2);   mul_b = MUL_B_W'(b1); end
            OP_NXA:  begin mul_a = c1_reg;         mul_b = MUL_B_W'(b2); end
            OP_NXB:  begin mul_a = c2_reg;         mul_b = MUL_B_W'(b1); end
            OP_NYA:  begin mul_a = c2_reg;         mul_b = MUL_B_W'(a1); end
            OP_NYB:  begin mul_a = c1_reg;         mul_b = MUL_B_W'(a2); end
            default: begin mul_a = '0;             mul_b = '0; end
        endcase
    end

    poe_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    assign div_num = (cmd.op == OP_DIVY) ? ny_reg : nx_reg;

    poe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (det_reg),
        .done  (div_done),
        .quot  (quot)
    );

    assign det_abs  = det_reg[DEN_W-1] ? DEN_W'(-det_reg) : DEN_W'(det_reg);
    assign parallel = (det_reg == '0) || (det_abs < DEN_W'({tol_reg, 16'h0000}));

    always_comb
    begin
        emit_val = '0;
        case (cmd.emit_sel)
            EM_START: emit_val = '{out_x: nsx_reg, out_y: nsy_reg,
                                   parallel_error: 1'b0, out_last: 1'b0};
            EM_INTER: emit_val = '{out_x: rx_reg, out_y: ry_reg,
                                   parallel_error: perr_reg, out_last: 1'b0};
            EM_END:   emit_val = '{out_x: nex_reg, out_y: ney_reg,
                                   parallel_error: 1'b0, out_last: 1'b1};
            default:  emit_val = '{out_x: '0, out_y: '0,
                                   parallel_error: 1'b1, out_last: 1'b1};
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg      <= OFFSET_DISTANCE_RESET;
            tol_reg       <= PARALLEL_TOLERANCE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == REG_OFFSET_DISTANCE)
                dist_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_PARALLEL_TOLERANCE)
                tol_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_reg <= emit_val;
        if (cmd.commit)
        begin
            pvx_reg <= vx_reg;
            pvy_reg <= vy_reg;
            ssx_reg <= nsx_reg;
            ssy_reg <= nsy_reg;
            sex_reg <= nex_reg;
            sey_reg <= ney_reg;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                vx_reg <= vertex.vertex_x;
                vy_reg <= vertex.vertex_y;
            end
            OP_SEG:
            begin
                nsx_reg <= sat(PROD_W'(pvx_reg) + PROD_W'(px_reg));
                nsy_reg <= sat(PROD_W'(pvy_reg) + PROD_W'(py_reg));
                nex_reg <= sat(PROD_W'(vx_reg) + PROD_W'(px_reg));
                ney_reg <= sat(PROD_W'(vy_reg) + PROD_W'(py_reg));
            end
            OP_CHECK:
            begin
                perr_reg <= parallel;
                rx_reg   <= '0;
                ry_reg   <= '0;
            end
            default:
            begin
            end
        endcase
        if (mul_done)
        begin
            case (cmd.op)
                OP_PX:   px_reg  <= prod[PERP_W+15:16];
                OP_PY:   py_reg  <= prod[PERP_W+15:16];
                OP_C1A:  c1_reg  <= prod[MUL_A_W-1:0];
                OP_C1B:  c1_reg  <= c1_reg + prod[MUL_A_W-1:0];
                OP_C2A:  c2_reg  <= prod[MUL_A_W-1:0];
                OP_C2B:  c2_reg  <= c2_reg + prod[MUL_A_W-1:0];
                OP_DETA: det_reg <= prod[DEN_W-1:0];
                OP_DETB: det_reg <= det_reg - prod[DEN_W-1:0];
                OP_NXA:  nx_reg  <= prod;
                OP_NXB:  nx_reg  <= nx_reg - prod;
                OP_NYA:  ny_reg  <= prod;
                OP_NYB:  ny_reg  <= ny_reg - prod;
                default:
                begin
                end
            endcase
        end
        if (div_done)
        begin
            if (cmd.op == OP_DIVY)
                ry_reg <= sat(quot);
            else
                rx_reg <= sat(quot);
        end
    end

    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign status.parallel = parallel;
    assign status.out_free = !out_valid_reg || !result_stall;

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

// ----- rtl/core/poe_ctrl.sv -----
`timescale 1ns / 1ps

module poe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vertex_valid,
    input  logic                  vertex_last,
    input  poe_pkg::dp_status_t   status,
    output poe_pkg::dp_cmd_t      cmd,
    output logic                  vertex_stall
);
    import poe_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   last_reg, last_next;
    logic   launched_reg, launched_next;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        last_next     = last_reg;
        launched_next = launched_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (vertex_valid)
                begin
                    last_next  = vertex_last;
                    state_next = (phase_reg == PH_VERTEX || phase_reg == PH_SEGMENT)
                                 ? ST_PX : ST_P0;
                end
            end
            ST_P0:
            begin
                if (!last_reg || status.out_free)
                begin
                    phase_next = last_reg ? PH_EMPTY : PH_VERTEX;
                    state_next = ST_IDLE;
                end
            end
            ST_PX, ST_PY, ST_C1A, ST_C1B, ST_C2A, ST_C2B, ST_DETA, ST_DETB,
            ST_NXA, ST_NXB, ST_NYA, ST_NYB:
            begin
                launched_next = !status.mul_done;
                if (status.mul_done)
                begin
                    unique case (state_reg)
                        ST_PX:   state_next = ST_PY;
                        ST_PY:   state_next = ST_SEG;
                        ST_C1A:  state_next = ST_C1B;
                        ST_C1B:  state_next = ST_C2A;
                        ST_C2A:  state_next = ST_C2B;
                        ST_C2B:  state_next = ST_DETA;
                        ST_DETA: state_next = ST_DETB;
                        ST_DETB: state_next = ST_NXA;
                        ST_NXA:  state_next = ST_NXB;
                        ST_NXB:  state_next = ST_NYA;
                        ST_NYA:  state_next = ST_NYB;
                        default: state_next = ST_CHECK;
                    endcase
                end
            end
            ST_SEG:
                state_next = (phase_reg == PH_VERTEX) ? ST_EMIT_A : ST_C1A;
            ST_CHECK:
                state_next = status.parallel ? ST_EMIT_A : ST_DIVX;
            ST_DIVX, ST_DIVY:
            begin
                launched_next = !status.div_done;
                if (status.div_done)
                    state_next = (state_reg == ST_DIVX) ? ST_DIVY : ST_EMIT_A;
            end
            ST_EMIT_A:
            begin
                if (status.out_free)
                begin
                    if (last_reg)
                        state_next = ST_EMIT_B;
                    else
                    begin
                        phase_next = PH_SEGMENT;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT_B:
            begin
                if (status.out_free)
                begin
                    phase_next = PH_EMPTY;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '{op: OP_NONE, mul_start: 1'b0, div_start: 1'b0, emit: 1'b0,
                emit_sel: EM_ERR, commit: 1'b0};
        unique case (state_reg)
            ST_IDLE:  cmd.op = vertex_valid ? OP_LOAD : OP_NONE;
            ST_P0:
            begin
                cmd.emit   = last_reg && status.out_free;
                cmd.commit = !last_reg || status.out_free;
            end
            ST_PX:    cmd.op = OP_PX;
            ST_PY:    cmd.op = OP_PY;
            ST_SEG:   cmd.op = OP_SEG;
            ST_C1A:   cmd.op = OP_C1A;
            ST_C1B:   cmd.op = OP_C1B;
            ST_C2A:   cmd.op = OP_C2A;
            ST_C2B:   cmd.op = OP_C2B;
            ST_DETA:  cmd.op = OP_DETA;
            ST_DETB:  cmd.op = OP_DETB;
            ST_NXA:   cmd.op = OP_NXA;
            ST_NXB:   cmd.op = OP_NXB;
            ST_NYA:   cmd.op = OP_NYA;
            ST_NYB:   cmd.op = OP_NYB;
            ST_CHECK: cmd.op = OP_CHECK;
            ST_DIVX:  cmd.op = OP_DIVX;
            ST_DIVY:  cmd.op = OP_DIVY;
            ST_EMIT_A:
            begin
                cmd.emit     = status.out_free;
                cmd.emit_sel = (phase_reg == PH_VERTEX) ? EM_START : EM_INTER;
                cmd.commit   = status.out_free && !last_reg;
            end
            ST_EMIT_B:
            begin
                cmd.emit     = status.out_free;
                cmd.emit_sel = EM_END;
                cmd.commit   = status.out_free;
            end
            default:  cmd.op = OP_NONE;
        endcase
        unique case (state_reg) inside
            ST_PX, ST_PY, ST_C1A, ST_C1B, ST_C2A, ST_C2B, ST_DETA, ST_DETB,
            ST_NXA, ST_NXB, ST_NYA, ST_NYB:
                cmd.mul_start = !launched_reg;
            ST_DIVX, ST_DIVY:
                cmd.div_start = !launched_reg;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_EMPTY;
            last_reg     <= 1'b0;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            last_reg     <= last_next;
            launched_reg <= launched_next;
        end
    end

    assign vertex_stall = (state_reg != ST_IDLE);

endmodule

// ----- rtl/core/polyline_offset_engine.sv -----
`timescale 1ns / 1ps

// channel   handshake                    payload
// -------   ---------------------------  -----------------------------------
// vertex    vertex_valid / vertex_stall  vertex_t: x, y (Q16.16), last
// result    result_valid / result_stall  result_t: x, y, parallel_error, last
// cfg       cfg_valid / cfg_ready        cfg_index, cfg_data (32 bits)
//
// Per item: a first vertex is loaded and committed, a second computes two products, a join
// vertex computes twelve products on the shared two-digit multiplier
// and two 102-step radix-2 divisions by det.
// A parallel join skips the divisions.
// The divider is the main cost; a final vertex adds a second emit.
// rst_n is asynchronous, active low; control and config go to reset values.
// A held result does not block the computing of the item; the engine only waits on
// result_stall when it must emit while the output register is still full.

module polyline_offset_engine #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          vertex_valid,
    output logic                          vertex_stall,
    input  poe_pkg::vertex_t              vertex,
    output logic                          result_valid,
    input  logic                          result_stall,
    output poe_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [poe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import poe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // the user must write registers only while idle; this block does not enforce it, so always ready
    assign cfg_ready = 1'b1;

    poe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_last  (vertex.vertex_last),
        .status       (status),
        .cmd          (cmd),
        .vertex_stall (vertex_stall)
    );

    poe_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .vertex       (vertex),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

// ----- rtl/core/poe_checker.sv -----
`timescale 1ns / 1ps

module poe_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             vertex_valid,
    input logic             vertex_stall,
    input logic             result_valid,
    input logic             result_stall,
    input poe_pkg::result_t result
);
    import poe_pkg::*;

    // busy right after an accepted vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && !vertex_stall |=> vertex_stall)
        else $error("vertex accepted but engine not busy");

    // error points are always the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.parallel_error |->
            result.out_x == 0 && result.out_y == 0)
        else $error("error result with nonzero point");

    // new results only come out of a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(vertex_stall))
        else $error("result appeared from idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule

bind polyline_offset_engine poe_checker u_poe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- sim/poe_checker.sv -----
`timescale 1ns / 1ps

module poe_scoreboard (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vertex_valid,
    input  logic             vertex_stall,
    input  poe_pkg::vertex_t vertex,
    input  logic             result_valid,
    input  logic             result_stall,
    input  poe_pkg::result_t result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [poe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]      cfg_data,
    output int               fail_count,
    output int               pending,
    output int               result_count,
    output int               error_count
);
    import poe_pkg::*;

    logic signed [31:0] dist_q;
    logic [31:0]        tol_q;
    logic signed [31:0] prev_x, prev_y;
    logic signed [31:0] seg_sx, seg_sy, seg_ex, seg_ey;
    phase_t             phase;
    result_t            offset_points[$];

    function automatic logic signed [31:0] sat32(logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'sh7fffffff;
        if (v < -128'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic void queue_point(input result_t r);
        offset_points = {offset_points, r};
    endfunction

    task automatic build_segment(input logic signed [31:0] x0, y0, x1, y1,
                                 output logic signed [31:0] sx, sy, ex, ey);
        logic signed [127:0] px, py;
        px = ((-($signed({{96{y1[31]}}, y1}) - y0)) * dist_q) >>> 16;
        py = (($signed({{96{x1[31]}}, x1}) - x0) * dist_q) >>> 16;
        sx = sat32(px + x0);
        sy = sat32(py + y0);
        ex = sat32(px + x1);
        ey = sat32(py + y1);
    endtask

    // miter point of two offset lines; returns 0 when near parallel
    function automatic logic miter_point(
        input logic signed [31:0] s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y,
        output logic signed [31:0] rx, ry);
        logic signed [127:0] a1, b1, c1, a2, b2, c2, det, mag, thr, nx, ny;
        a1 = $signed({{96{e1y[31]}}, e1y}) - s1y;
        b1 = $signed({{96{s1x[31]}}, s1x}) - e1x;
        c1 = a1 * s1x + b1 * s1y;
        a2 = $signed({{96{e2y[31]}}, e2y}) - s2y;
        b2 = $signed({{96{s2x[31]}}, s2x}) - e2x;
        c2 = a2 * s2x + b2 * s2y;
        det = a1 * b2 - a2 * b1;
        mag = det < 0 ? -det : det;
        thr = $signed({80'd0, tol_q, 16'd0});
        rx = 0;
        ry = 0;
        if (det == 0 || mag < thr)
            return 1'b0;
        nx = b2 * c1 - b1 * c2;
        ny = a1 * c2 - a2 * c1;
        rx = sat32(nx / det);   // SV division truncates toward zero
        ry = sat32(ny / det);
        return 1'b1;
    endfunction

    task automatic predict_vertex(input vertex_t v);
        logic signed [31:0] o_sx, o_sy, o_ex, o_ey, ix, iy;
        result_t r;
        if (phase == PH_VERTEX || phase == PH_SEGMENT) begin
            o_sx = seg_sx; o_sy = seg_sy; o_ex = seg_ex; o_ey = seg_ey;
            build_segment(prev_x, prev_y, v.vertex_x, v.vertex_y,
                          seg_sx, seg_sy, seg_ex, seg_ey);
            if (phase == PH_VERTEX) begin
                r = '{seg_sx, seg_sy, 1'b0, 1'b0};
            end
            else if (miter_point(o_sx, o_sy, o_ex, o_ey,
                                 seg_sx, seg_sy, seg_ex, seg_ey, ix, iy)) begin
                r = '{ix, iy, 1'b0, 1'b0};
            end
            else begin
                r = '{32'sd0, 32'sd0, 1'b1, 1'b0};
            end
            queue_point(r);
            if (v.vertex_last)
                queue_point('{seg_ex, seg_ey, 1'b0, 1'b1});
            phase = v.vertex_last ? PH_EMPTY : PH_SEGMENT;
        end
        else begin
            // lone vertex ending a polyline: single error point
            if (v.vertex_last)
                queue_point('{32'sd0, 32'sd0, 1'b1, 1'b1});
            phase = v.vertex_last ? PH_EMPTY : PH_VERTEX;
        end
        prev_x = v.vertex_x;
        prev_y = v.vertex_y;
    endtask

    assign pending = offset_points.size();

    always @(posedge clk or negedge rst_n) begin
        result_t exp_r;
        int      errs;
        errs = 0;
        if (!rst_n) begin
            dist_q = OFFSET_DISTANCE_RESET;
            tol_q = PARALLEL_TOLERANCE_RESET;
            phase = PH_EMPTY;
            prev_x = 0; prev_y = 0;
            seg_sx = 0; seg_sy = 0; seg_ex = 0; seg_ey = 0;
            fail_count <= 0;
            result_count <= 0;
            error_count <= 0;
            offset_points.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_OFFSET_DISTANCE)
                    dist_q = cfg_data;
                else if (cfg_index == REG_PARALLEL_TOLERANCE)
                    tol_q = cfg_data;
            end
            if (result_valid && !result_stall) begin
                result_count <= result_count + 1;
                if (result.parallel_error)
                    error_count <= error_count + 1;
                if (offset_points.size() == 0) begin
                    $error("unexpected result x=%0d y=%0d", result.out_x, result.out_y);
                    errs++;
                end
                else begin
                    exp_r = offset_points.pop_front();
                    if (result.out_x !== exp_r.out_x) begin
                        $error("out_x expected %0d got %0d", exp_r.out_x, result.out_x);
                        errs++;
                    end
                    if (result.out_y !== exp_r.out_y) begin
                        $error("out_y expected %0d got %0d", exp_r.out_y, result.out_y);
                        errs++;
                    end
                    if (result.parallel_error !== exp_r.parallel_error) begin
                        $error("parallel_error expected %0b got %0b",
                               exp_r.parallel_error, result.parallel_error);
                        errs++;
                    end
                    if (result.out_last !== exp_r.out_last) begin
                        $error("out_last expected %0b got %0b",
                               exp_r.out_last, result.out_last);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            // predict after popping so a same-edge result cannot match itself
            if (vertex_valid && !vertex_stall)
                predict_vertex(vertex);
        end
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import poe_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 vertex_valid;
    logic                 vertex_stall;
    vertex_t              vertex;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int fail_count, pending, result_count, error_count;
    int send_idle_pct;      // sender gap chance, percent
    int recv_stall_pct;     // receiver stall chance, percent
    int hold_cycles;        // >0: receiver holds off for this many cycles
    int vertices_sent;

    polyline_offset_engine uut (
        .clk(clk), .rst_n(rst_n),
        .vertex_valid(vertex_valid), .vertex_stall(vertex_stall), .vertex(vertex),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    poe_scoreboard checker_i (
        .clk(clk), .rst_n(rst_n),
        .vertex_valid(vertex_valid), .vertex_stall(vertex_stall), .vertex(vertex),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .result_count(result_count), .error_count(error_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stalls, or a long counted hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // global watchdog
    initial
    begin
        #200_000_000;
        $display("polyline_offset_engine test failed");
        $finish;
    end

    // one item on the vertex channel; valid may stay high across items
    task automatic send_vertex(input logic signed [31:0] x, y, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            vertex_valid <= 1'b0;
            @(negedge clk);
        end
        vertex_valid <= 1'b1;
        vertex <= '{x, y, last};
        @(posedge clk);
        while (vertex_stall)
            @(posedge clk);
        vertices_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // let the engine drain before touching config
    task automatic drain;
        int guard;
        guard = 0;
        vertex_valid <= 1'b0;
        while (pending != 0 && guard < 2_000_000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (400) @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord(input int mode);
        case (mode)
            0: return $signed($urandom_range(20, 0) << 16) - (10 << 16);
            1: return $signed($urandom_range(2000, 0) << 12) - (1000 << 12);
            2: return $signed($urandom());
            default: return $signed($urandom_range(200000, 0)) - 100000;
        endcase
    endfunction

    // a well-formed polyline of n vertices with random content
    task automatic send_polyline(input int n, input int mode);
        for (int i = 0; i < n; i++)
            send_vertex(rand_coord(mode), rand_coord(mode), i == n - 1);
    endtask

    initial
    begin
        int mode;
        vertex_valid = 1'b0;
        vertex = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_OFFSET_DISTANCE;
        cfg_data = '0;
        result_stall = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        vertices_sent = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: square corner, lone vertex, repeated vertex, extremes, collinear run, short pair
        send_vertex(0, 0, 1'b0);
        send_vertex(32'sd10 <<< 16, 0, 1'b0);
        send_vertex(32'sd10 <<< 16, 32'sd10 <<< 16, 1'b1);
        send_vertex(32'sd5, 32'sd7, 1'b1);
        send_vertex(32'sd1 <<< 16, 32'sd1 <<< 16, 1'b0);
        send_vertex(32'sd1 <<< 16, 32'sd1 <<< 16, 1'b0);
        send_vertex(32'sd3 <<< 16, 32'sd2 <<< 16, 1'b1);
        send_vertex(32'sh80000000, 32'sh7fffffff, 1'b0);
        send_vertex(32'sh7fffffff, 32'sh80000000, 1'b0);
        send_vertex(32'sh80000000, 32'sh80000000, 1'b0);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 1'b1);
        send_vertex(0, 0, 1'b0);
        send_vertex(32'sd1 <<< 16, 0, 1'b0);
        send_vertex(32'sd2 <<< 16, 0, 1'b0);
        send_vertex(32'sd3 <<< 16, 32'sd1 <<< 16, 1'b1);
        send_vertex(-1, -1, 1'b0);
        send_vertex(0, 0, 1'b1);
        drain();

        // settings sweep: extremes and random values of distance and tolerance, idle and stall phases
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                0: begin write_reg(REG_OFFSET_DISTANCE, 32'h7fffffff);
                         write_reg(REG_PARALLEL_TOLERANCE, 32'h0); end
                1: begin write_reg(REG_OFFSET_DISTANCE, 32'h80000000);
                         write_reg(REG_PARALLEL_TOLERANCE, 32'hffffffff); end
                2: begin write_reg(REG_OFFSET_DISTANCE, 32'hffff8000);
                         write_reg(REG_PARALLEL_TOLERANCE, 32'd1); end
                3: begin write_reg(REG_OFFSET_DISTANCE, 32'd0);
                         write_reg(REG_PARALLEL_TOLERANCE, 32'd100); end
                default: begin write_reg(REG_OFFSET_DISTANCE, $urandom());
                         write_reg(REG_PARALLEL_TOLERANCE, $urandom_range(1 << 20)); end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if (ph == 2)
                hold_cycles = 3000;   // long hold-off: engine fills and stalls input
            while (vertices_sent < 18 + (ph + 1) * 250)
            begin
                mode = $urandom_range(3);
                if ($urandom_range(9) == 0)
                    send_vertex(rand_coord(mode), rand_coord(mode), 1'($urandom_range(1)));
                else
                    send_polyline($urandom_range(6, 1), mode);
            end
        end
        send_polyline(3, 0);   // close any open polyline
        drain();

        $display("covered %0d vertices, %0d offset points (%0d flagged parallel)",
                 vertices_sent, result_count, error_count);
        if (pending != 0)
            $error("%0d expected offset points never came out", pending);
        if (fail_count == 0 && pending == 0)
            $display("polyline_offset_engine test passed");
        else
            $display("polyline_offset_engine test failed");
        $finish;
    end

endmodule
